>>> hdl/qpht_pkg.sv
// Shared types and constants of the quadratic-probing hash table.
// Holds the field widths, the status codes and the controller state type.
// Depends on nothing; the interfaces, the modulo unit, the table and the testbench import it.
`default_nettype none

package qpht_pkg;

  localparam int TABLE_SIZE_DEF = 11;

  localparam int KEY_W     = 31;
  localparam int PAYLOAD_W = 32;
  localparam int STATUS_W  = 2;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t STAT_INSERTED  = 2'd0;
  localparam status_t STAT_FULL      = 2'd1;
  localparam status_t STAT_FOUND     = 2'd2;
  localparam status_t STAT_NOT_FOUND = 2'd3;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

>>> hdl/qpht_ifs.sv
// Valid/ready channel interfaces of the hash table: requests and results.
// Depends on qpht_pkg for the field widths and the status type.
`default_nettype none

interface qpht_in_if;
  import qpht_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [KEY_W-1:0]     key;
  logic [PAYLOAD_W-1:0] payload;

  modport source (output valid, kind, key, payload, input ready);
  modport sink   (input valid, kind, key, payload, output ready);
endinterface

interface qpht_out_if;
  import qpht_pkg::*;

  logic                 valid;
  logic                 ready;
  status_t              status;
  logic [PAYLOAD_W-1:0] found_payload;

  modport source (output valid, status, found_payload, input ready);
  modport sink   (input valid, status, found_payload, output ready);
endinterface

`default_nettype wire

>>> hdl/qpht_hash.sv
// Key-modulo unit: key mod TABLE_SIZE by reciprocal multiplication, quotient and remainder registered in turn.
// Depends on qpht_pkg for the key width.
`default_nettype none

module qpht_hash #(
  parameter int TABLE_SIZE = qpht_pkg::TABLE_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [qpht_pkg::KEY_W-1:0]    key,
  output logic                          done,
  output logic [$clog2(TABLE_SIZE)-1:0] rem
);
  import qpht_pkg::*;

  localparam int AW      = $clog2(TABLE_SIZE);
  localparam int RECIP_W = KEY_W + 1;
  localparam int PROD_W  = KEY_W + RECIP_W;
  localparam int SHIFT   = KEY_W + AW;
  // The reciprocal is rounded up; its error times any key stays below 2^SHIFT, so the
  // shifted product is the exact quotient.
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(TABLE_SIZE - 1)) / 64'(TABLE_SIZE);
  localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'(RECIP_FULL);
  localparam logic [KEY_W-1:0]   DIVISOR = KEY_W'(TABLE_SIZE);

  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [KEY_W-1:0]  quo_r, quo_nxt;
  logic [AW-1:0]     rem_r, rem_nxt;
  logic              stage_r;
  logic              done_r;
  logic [PROD_W-1:0] prod;
  logic [KEY_W-1:0]  diff;

  // The quotient is registered first; the remainder is then formed from it and registered.
  assign prod = PROD_W'(key) * PROD_W'(RECIP);
  assign diff = key_r - quo_r * DIVISOR;

  always_comb begin
    key_nxt = key_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    if (start) begin
      key_nxt = key;
      quo_nxt = KEY_W'(prod >> SHIFT);
    end
    if (stage_r) begin
      rem_nxt = AW'(diff);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      stage_r <= start;
      done_r  <= stage_r;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

>>> hdl/qpht_mem.sv
// Slot memory: one write port and one read port, read data registered.
// Generic; depends on nothing but its parameters.
`default_nettype none

module qpht_mem #(
  parameter int DEPTH = 11,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> hdl/quadratic_probe_hash_table.sv
// Open-addressing hash table with quadratic probing over TABLE_SIZE slots. Every request
// beat (insert or search) yields exactly one result beat. The home slot is key mod
// TABLE_SIZE, formed by a multiplication with a fixed reciprocal; probe i then visits
// (home + i*i) mod TABLE_SIZE, with the square kept up incrementally, and each probe is
// one read of the slot memory, which holds a valid flag, the key and the payload in one
// word. The read of the next slot is issued while the current one is checked, so probing
// runs one slot per cycle; an item takes from 1 to TABLE_SIZE probes, and the memory read
// port sets the probe rate. Inserts write the first empty slot met, with no duplicate
// check, or report full; a search stops at a key match, at an empty slot or after the
// last probe. The block takes one request at a time. After reset a clearing pass writes
// every slot empty, one slot per cycle, before the first request beat is taken. A
// finished result sits in an output register, so the next request is taken while the
// result still waits for its consumer.
`default_nettype none

module quadratic_probe_hash_table #(
  parameter int TABLE_SIZE = qpht_pkg::TABLE_SIZE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  qpht_in_if.sink    in_ch,
  qpht_out_if.source out_ch
);
  import qpht_pkg::*;

  localparam int AW      = $clog2(TABLE_SIZE);
  localparam int ENTRY_W = 1 + KEY_W + PAYLOAD_W;
  localparam logic [AW:0]   MODULUS = (AW + 1)'(TABLE_SIZE);
  localparam logic [AW-1:0] LAST    = AW'(TABLE_SIZE - 1);

  state_t state_r, state_nxt;

  // Clearing pass address.
  logic [AW-1:0] clr_r, clr_nxt;

  // The request being worked on.
  logic                 kind_r;
  logic [KEY_W-1:0]     key_r;
  logic [PAYLOAD_W-1:0] payload_r;

  // Probe position, distance to the next probe ((2i+1) mod size) and probe number.
  logic [AW-1:0] pos_r, pos_nxt;
  logic [AW-1:0] d_r, d_nxt;
  logic [AW-1:0] step_r, step_nxt;

  // Result held between the end of probing and the output register.
  status_t              res_status_r, res_status_nxt;
  logic [PAYLOAD_W-1:0] res_tag_r, res_tag_nxt;

  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [PAYLOAD_W-1:0] out_tag_r, out_tag_nxt;

  logic                 in_fire;
  logic                 hash_done;
  logic [AW-1:0]        hash_rem;

  logic                 mem_wr_en;
  logic [AW-1:0]        mem_wr_addr;
  logic [ENTRY_W-1:0]   mem_wr_data;
  logic                 mem_rd_en;
  logic [ENTRY_W-1:0]   mem_rd_data;

  logic                 ent_valid;
  logic [KEY_W-1:0]     ent_key;
  logic [PAYLOAD_W-1:0] ent_tag;
  logic                 key_hit;
  logic                 probe_end;
  logic                 out_free;
  logic [AW:0]          pos_sum;
  logic [AW:0]          d_sum;
  logic [AW-1:0]        pos_adv;
  logic [AW-1:0]        d_adv;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  qpht_hash #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_fire),
    .key   (in_ch.key),
    .done  (hash_done),
    .rem   (hash_rem)
  );

  qpht_mem #(
    .DEPTH (TABLE_SIZE),
    .WIDTH (ENTRY_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (pos_nxt),
    .rd_data (mem_rd_data)
  );

  // The read data always belongs to the slot at pos_r while probing.
  assign ent_valid = mem_rd_data[ENTRY_W-1];
  assign ent_key   = mem_rd_data[PAYLOAD_W +: KEY_W];
  assign ent_tag   = mem_rd_data[PAYLOAD_W-1:0];
  assign key_hit   = ent_valid && (ent_key == key_r);

  // Inserts stop at the first empty slot, searches also at a matching key; both stop after the last probe.
  assign probe_end = !ent_valid || (kind_r == KIND_SEARCH && key_hit) || (step_r == LAST);

  // Both sums stay below twice the table size, so one conditional subtract reduces them.
  assign pos_sum = {1'b0, pos_r} + {1'b0, d_r};
  assign d_sum   = {1'b0, d_r} + (AW + 1)'(2);
  assign pos_adv = (pos_sum >= MODULUS) ? AW'(pos_sum - MODULUS) : pos_sum[AW-1:0];
  assign d_adv   = (d_sum >= MODULUS) ? AW'(d_sum - MODULUS) : d_sum[AW-1:0];

  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_HASH;
        end
      end
      ST_HASH: begin
        if (hash_done) begin
          state_nxt = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (probe_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    clr_nxt        = clr_r;
    pos_nxt        = pos_r;
    d_nxt          = d_r;
    step_nxt       = step_r;
    res_status_nxt = res_status_r;
    res_tag_nxt    = res_tag_r;
    out_status_nxt = out_status_r;
    out_tag_nxt    = out_tag_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    mem_wr_en      = 1'b0;
    mem_wr_addr    = pos_r;
    mem_wr_data    = {1'b1, key_r, payload_r};
    mem_rd_en      = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_r;
        mem_wr_data = '0;
        clr_nxt     = clr_r + 1'b1;
      end
      ST_HASH: begin
        // Home slot: probe zero, first distance one.
        if (hash_done) begin
          pos_nxt   = hash_rem;
          d_nxt     = AW'(1);
          step_nxt  = '0;
          mem_rd_en = 1'b1;
        end
      end
      ST_PROBE: begin
        res_tag_nxt = '0;
        if (kind_r == KIND_INSERT) begin
          res_status_nxt = ent_valid ? STAT_FULL : STAT_INSERTED;
          mem_wr_en      = !ent_valid;
        end else if (key_hit) begin
          res_status_nxt = STAT_FOUND;
          res_tag_nxt    = ent_tag;
        end else begin
          res_status_nxt = STAT_NOT_FOUND;
        end
        if (!probe_end) begin
          pos_nxt   = pos_adv;
          d_nxt     = d_adv;
          step_nxt  = step_r + 1'b1;
          mem_rd_en = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_tag_nxt    = res_tag_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r    <= in_ch.kind;
      key_r     <= in_ch.key;
      payload_r <= in_ch.payload;
    end
    pos_r        <= pos_nxt;
    d_r          <= d_nxt;
    step_r       <= step_nxt;
    res_status_r <= res_status_nxt;
    res_tag_r    <= res_tag_nxt;
    out_status_r <= out_status_nxt;
    out_tag_r    <= out_tag_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.found_payload = out_tag_r;

  // A slot is only ever written by the clearing pass or by an insert.
  a_write_only_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_wr_en && state_r == ST_PROBE) |-> (kind_r == KIND_INSERT && !ent_valid))
    else $error("slot written outside an insert into an empty slot");

  // The probe position and the probe count stay inside the table.
  a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROBE) |-> ({1'b0, pos_r} < MODULUS && {1'b0, step_r} < MODULUS))
    else $error("probe position or count out of range");

  // Only a found result carries a payload.
  a_tag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != STAT_FOUND) |-> (out_tag_r == '0))
    else $error("payload returned without a match");

  // The home slot is read in the same cycle the modulo unit finishes.
  a_hash_to_probe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HASH && hash_done) |-> mem_rd_en ##1 (state_r == ST_PROBE))
    else $error("home slot read not issued after hashing");

  // No request is taken until the clearing pass has covered every slot.
  a_clear_before_use: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR && clr_r != LAST) |=> (state_r == ST_CLEAR))
    else $error("clearing pass cut short");

endmodule

`default_nettype wire

>>> tb/tb_quadratic_probe_hash_table.sv
`timescale 1ns / 1ps
// Self-checking testbench for quadratic_probe_hash_table: directed and random inserts and
// searches with random stalls on both channels. Depends on qpht_pkg, qpht_ifs and the RTL.

module tb_quadratic_probe_hash_table;
  import qpht_pkg::*;

  localparam int TABLE_SIZE = TABLE_SIZE_DEF;

  // Stimulus sizing. The long receiver hold-off starts once PRESSURE_AT requests are in.
  localparam int RANDOM_ITEMS  = 1690;
  localparam int PRESSURE_AT   = 400;
  localparam int PRESSURE_HOLD = 300;
  localparam int DRAIN_CYCLES  = 40;
  localparam int REPORT_LIMIT  = 10;

  localparam logic [KEY_W-1:0]     KEY_MAX     = '1;
  localparam logic [PAYLOAD_W-1:0] PAYLOAD_MAX = '1;

  // One expected result beat.
  typedef struct {
    status_t              status;
    logic [PAYLOAD_W-1:0] found_payload;
  } answer_t;

  // Shadow copy of the slot table. Each accepted request is applied to it in acceptance
  // order, which is also the order in which the block serves requests, and the answer it
  // gives is queued until the matching result beat comes back.
  class shadow_table;
    bit                   slot_used[TABLE_SIZE];
    logic [KEY_W-1:0]     slot_key[TABLE_SIZE];
    logic [PAYLOAD_W-1:0] slot_tag[TABLE_SIZE];
    answer_t              awaited[$];
    int                   mismatches;

    function void record_request(logic kind, logic [KEY_W-1:0] key,
                                 logic [PAYLOAD_W-1:0] payload);
      int      home;
      int      pos;
      int      i;
      bit      done;
      answer_t ans;
      ans.status        = (kind == KIND_INSERT) ? STAT_FULL : STAT_NOT_FOUND;
      ans.found_payload = '0;
      home = int'(key % TABLE_SIZE);
      done = 1'b0;
      for (i = 0; i < TABLE_SIZE && !done; i++) begin
        pos = (home + (i * i) % TABLE_SIZE) % TABLE_SIZE;
        if (kind == KIND_INSERT) begin
          if (!slot_used[pos]) begin
            slot_used[pos] = 1'b1;
            slot_key[pos]  = key;
            slot_tag[pos]  = payload;
            ans.status     = STAT_INSERTED;
            done           = 1'b1;
          end
        end else if (!slot_used[pos]) begin
          done = 1'b1;
        end else if (slot_key[pos] == key) begin
          ans.status        = STAT_FOUND;
          ans.found_payload = slot_tag[pos];
          done              = 1'b1;
        end
      end
      awaited.push_back(ans);
    endfunction

    function void check_response(status_t status, logic [PAYLOAD_W-1:0] found_payload);
      answer_t ans;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result beat: status %0d payload %h", status, found_payload);
        return;
      end
      ans = awaited.pop_front();
      if (status !== ans.status || found_payload !== ans.found_payload) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("result mismatch: status exp %0d got %0d, payload exp %h got %h",
                   ans.status, status, ans.found_payload, found_payload);
      end
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction

    function int fail_count();
      return mismatches + awaited.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  qpht_in_if  req_if ();
  qpht_out_if rsp_if ();

  quadratic_probe_hash_table #(
    .TABLE_SIZE (TABLE_SIZE)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_if),
    .out_ch (rsp_if)
  );

  shadow_table      tracker = new();
  int               accepted_requests = 0;
  logic [KEY_W-1:0] inserted_keys[$];

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Most gaps and stalls are short; about one in ten is a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 90)
      return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one request beat and holds it until the block takes it. The valid line is
  // only raised here, so a back-to-back beat never sees valid lowered and raised again
  // within the same time step.
  task automatic send_request(input logic kind, input logic [KEY_W-1:0] key,
                              input logic [PAYLOAD_W-1:0] payload);
    req_if.valid   <= 1'b1;
    req_if.kind    <= kind;
    req_if.key     <= key;
    req_if.payload <= payload;
    do @(posedge clk); while (!req_if.ready);
    tracker.record_request(kind, key, payload);
    accepted_requests++;
    if (kind == KIND_INSERT)
      inserted_keys.push_back(key);
  endtask

  task automatic pause_requests(input int cycles);
    if (cycles > 0) begin
      req_if.valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Random request. The table holds only eleven slots and is never cleared, so it fills
  // early; after that, inserts report full and searches mostly walk complete probe chains.
  // Searches favor keys already inserted, and keys that share a home slot with them, so
  // that hits, duplicate chains and exhausted chains stay common.
  task automatic send_random_request();
    logic             kind;
    logic [KEY_W-1:0] key;
    int               pick;
    kind = ($urandom_range(0, 99) < 45) ? KIND_INSERT : KIND_SEARCH;
    pick = $urandom_range(0, 99);
    if (pick < 50 && inserted_keys.size() > 0)
      key = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
    else if (pick < 70 && inserted_keys.size() > 0)
      key = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)]
            + KEY_W'(TABLE_SIZE * $urandom_range(1, 1000));
    else if (pick < 82)
      key = KEY_W'($urandom_range(0, 50));
    else if (pick < 85)
      key = KEY_MAX - KEY_W'($urandom_range(0, 3));
    else
      key = KEY_W'($urandom);
    send_request(kind, key, $urandom);
  endtask

  // Result side: random stalls, quiet stretches with ready held high, and one long
  // hold-off that lets the block fill its output register and stall its input.
  initial begin : drain_results
    int hold;
    bit pressure_done;
    bit quiet;
    hold          = 0;
    pressure_done = 1'b0;
    quiet         = 1'b0;
    rsp_if.ready  = 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 299) == 0)
        quiet = !quiet;
      if (hold > 0)
        hold--;
      else if (!pressure_done && accepted_requests >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        hold          = PRESSURE_HOLD;
      end else if (!quiet && $urandom_range(0, 99) < 20)
        hold = pick_gap();
      rsp_if.ready <= (hold == 0) && rst_n;
    end
  end

  // Every result beat is checked at the edge that takes it.
  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready)
      tracker.check_response(rsp_if.status, rsp_if.found_payload);
  end

  initial begin : run_stimulus
    int n;
    rst_n          = 1'b0;
    req_if.valid   = 1'b0;
    req_if.kind    = KIND_INSERT;
    req_if.key     = '0;
    req_if.payload = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. A search on the empty table stops at the first empty slot.
    send_request(KIND_SEARCH, 31'd5, PAYLOAD_MAX);
    // Smallest and largest key and payload.
    send_request(KIND_INSERT, '0, '0);
    send_request(KIND_INSERT, KEY_MAX, PAYLOAD_MAX);
    send_request(KIND_SEARCH, '0, PAYLOAD_MAX);
    send_request(KIND_SEARCH, KEY_MAX, '0);
    // A second copy of key zero; the search must still return the first copy.
    send_request(KIND_INSERT, '0, 32'h1234_5678);
    send_request(KIND_SEARCH, '0, 32'h5555_aaaa);
    // Fill the whole probe chain of home slot zero. The last insert reports full even
    // though several slots are still empty, since the chain reaches only six of them.
    send_request(KIND_INSERT, 31'd11, 32'h0000_0011);
    send_request(KIND_INSERT, 31'd22, 32'h0000_0022);
    send_request(KIND_INSERT, 31'd33, 32'h0000_0033);
    pause_requests(5);
    send_request(KIND_INSERT, 31'd44, 32'h0000_0044);
    // Two searches that walk the full chain without a match, then one that finds key 33 in it.
    send_request(KIND_SEARCH, 31'd55, '0);
    send_request(KIND_SEARCH, 31'd44, '0);
    send_request(KIND_SEARCH, 31'd33, '0);
    // A home slot that is still empty, then filled.
    send_request(KIND_SEARCH, 31'd2, '0);
    send_request(KIND_INSERT, 31'd13, 32'hdead_beef);
    send_request(KIND_SEARCH, 31'd13, '0);

    // Random part. Every fourth block of a hundred items runs without sender gaps.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      send_random_request();
      if ((n % 400) < 300 && $urandom_range(0, 99) < 30)
        pause_requests(pick_gap());
    end
    req_if.valid <= 1'b0;

    while (tracker.outstanding() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.fail_count() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Far beyond the slowest correct run.
  initial begin : watchdog
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> filelist.f
hdl/qpht_pkg.sv
hdl/qpht_ifs.sv
hdl/qpht_hash.sv
hdl/qpht_mem.sv
hdl/quadratic_probe_hash_table.sv
tb/tb_quadratic_probe_hash_table.sv
